FILE: rtl/orc_pkg.sv
// shared types, constants and helpers for the obstacle radius classifier
`timescale 1ns / 1ps
package orc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int GRID_DIM    = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 13;
    localparam int COORD_W     = 20;
    localparam int ENTRY_W     = 2 * COORD_W;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W + 1;
    localparam int D2_W        = SQ_W + 1;
    localparam int R2_W        = 32;
    localparam int PROD_W      = 20;
    localparam int SUM_W       = 22;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OCC_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd4;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_CELL  = 2'd1;
    localparam logic [1:0] REQ_POINT = 2'd2;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_NEAR = 2'd1;
    localparam logic [1:0] KIND_NEW  = 2'd2;

    localparam logic signed [SUM_W-1:0] CLAMP_HI = 22'sd524287;
    localparam logic signed [SUM_W-1:0] CLAMP_LO = -22'sd524288;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [9:0]                cell_col;
        logic [9:0]                cell_row;
        logic signed [7:0]         cell_value;
        logic signed [COORD_W-1:0] point_x_mm;
        logic signed [COORD_W-1:0] point_y_mm;
    } t_req;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [CNT_W-1:0] table_count;
        logic             overflow;
    } t_res;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_dist_st;

    function automatic logic signed [COORD_W-1:0] clamp_coord(input logic signed [SUM_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > CLAMP_HI) begin
            r = CLAMP_HI[COORD_W-1:0];
        end else if (v < CLAMP_LO) begin
            r = CLAMP_LO[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/orc_ram.sv
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module orc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/orc_dist.sv
// pipelined squared distance and radius compare, one table entry per cycle
`timescale 1ns / 1ps
module orc_dist (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             i_flush,
    input  logic signed [orc_pkg::COORD_W-1:0] i_px,
    input  logic signed [orc_pkg::COORD_W-1:0] i_py,
    input  logic [orc_pkg::ENTRY_W-1:0]      i_entry,
    input  logic [orc_pkg::R2_W-1:0]         i_r2,
    output orc_pkg::t_dist_st                o_st
);
    import orc_pkg::*;

    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [DIFF_W-1:0]         adx;
    logic [DIFF_W-1:0]         ady;
    logic [2*DIFF_W-1:0]       prod_x;
    logic [2*DIFF_W-1:0]       prod_y;
    logic [D2_W-1:0]           d2;

    logic                      r_va;
    logic                      r_vb;
    logic [DIFF_W-1:0]         r_adx;
    logic [DIFF_W-1:0]         r_ady;
    logic [SQ_W-1:0]           r_sqx;
    logic [SQ_W-1:0]           r_sqy;

    assign tx  = i_entry[ENTRY_W-1:COORD_W];
    assign ty  = i_entry[COORD_W-1:0];
    assign dx  = $signed({i_px[COORD_W-1], i_px}) - $signed({tx[COORD_W-1], tx});
    assign dy  = $signed({i_py[COORD_W-1], i_py}) - $signed({ty[COORD_W-1], ty});
    assign adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    assign ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

    assign prod_x = (2*DIFF_W)'(r_adx) * (2*DIFF_W)'(r_adx);
    assign prod_y = (2*DIFF_W)'(r_ady) * (2*DIFF_W)'(r_ady);
    assign d2     = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_flush) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_adx <= adx;
        r_ady <= ady;
        r_sqx <= prod_x[SQ_W-1:0];
        r_sqy <= prod_y[SQ_W-1:0];
    end

    assign o_st.busy = r_va | r_vb;
    assign o_st.hit  = r_vb && (d2 < {{(D2_W-R2_W){1'b0}}, i_r2});

endmodule

FILE: rtl/obstacle_radius_classifier.sv
// top level: sequencer, config registers, obstacle table and distance unit
// a clear, unused, unoccupied or dropped request gives its result in the cycle after accept
// a stored map cell passes through S_MULX, S_MULY and S_WRITE before its result (one shared 10x10 multiplier)
// a scan point walks the table until a hit or its end: the table ram port feeds one entry a cycle
// synchronous active-low reset: count zero, registers to defaults, table ram not cleared
// one result strobe per request, the receiver cannot stall
`timescale 1ns / 1ps
module obstacle_radius_classifier (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  orc_pkg::t_req                    i_req,
    output logic                             o_res_strobe,
    output orc_pkg::t_res                    o_res,
    input  logic                             i_cfg_we,
    input  logic [orc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [orc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import orc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MULX  = 3'd1;
    localparam logic [2:0] S_MULY  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_issue, n_issue;
    logic                      r_rd_v, n_rd_v;
    logic                      r_strobe, n_strobe;
    t_res                      r_res, n_res;
    t_req                      r_req, n_req;
    logic [PROD_W-1:0]         r_prod;
    logic signed [COORD_W-1:0] r_xpos, n_xpos;
    logic [R2_W-1:0]           r_r2;

    logic [9:0]                r_cs;
    logic signed [COORD_W-1:0] r_ox;
    logic signed [COORD_W-1:0] r_oy;
    logic [6:0]                r_lvl;
    logic [15:0]               r_radius;

    logic [9:0]                mul_a;
    logic signed [SUM_W-1:0]   pos_sum;
    logic signed [COORD_W-1:0] ypos;
    logic                      cell_occ;
    logic                      do_issue;
    logic                      finish;
    logic                      ram_we;
    logic [ENTRY_W-1:0]        ram_rdata;
    t_dist_st                  dist_st;

    orc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[ADDR_W-1:0]),
        .i_wdata({r_xpos, ypos}),
        .i_raddr(r_issue[ADDR_W-1:0]),
        .o_rdata(ram_rdata)
    );

    orc_dist u_dist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_rd_v),
        .i_flush(finish),
        .i_px   (r_req.point_x_mm),
        .i_py   (r_req.point_y_mm),
        .i_entry(ram_rdata),
        .i_r2   (r_r2),
        .o_st   (dist_st)
    );

    assign mul_a    = (r_state == S_MULX) ? r_req.cell_col : r_req.cell_row;
    assign pos_sum  = $signed({2'b00, r_prod})
                    + $signed((r_state == S_MULY) ? {{2{r_ox[COORD_W-1]}}, r_ox}
                                                  : {{2{r_oy[COORD_W-1]}}, r_oy});
    assign ypos     = clamp_coord(pos_sum);
    assign cell_occ = (int'(i_req.cell_col) < GRID_DIM) && (int'(i_req.cell_row) < GRID_DIM)
                    && (i_req.cell_value > $signed({1'b0, r_lvl}));
    assign do_issue = r_issue < r_count;
    assign finish   = (r_state == S_SCAN)
                    && (dist_st.hit || (!do_issue && !r_rd_v && !dist_st.busy));

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_issue  = r_issue;
        n_strobe = 1'b0;
        n_res    = r_res;
        n_req    = r_req;
        n_xpos   = r_xpos;
        n_rd_v   = 1'b0;
        ram_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req             = i_req;
                    n_res.result_kind = KIND_ACK;
                    n_res.table_count = r_count;
                    n_res.overflow    = 1'b0;
                    case (i_req.req_type)
                        REQ_CLEAR: begin
                            n_count           = '0;
                            n_res.table_count = '0;
                            n_strobe          = 1'b1;
                        end
                        REQ_CELL: begin
                            if (!cell_occ) begin
                                n_strobe = 1'b1;
                            end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_res.overflow = 1'b1;
                                n_strobe       = 1'b1;
                            end else begin
                                n_state = S_MULX;
                            end
                        end
                        REQ_POINT: begin
                            n_issue = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_MULX: begin
                n_state = S_MULY;
            end
            S_MULY: begin
                n_xpos  = clamp_coord(pos_sum);
                n_state = S_WRITE;
            end
            S_WRITE: begin
                ram_we            = 1'b1;
                n_count           = r_count + 1'b1;
                n_res.result_kind = KIND_ACK;
                n_res.table_count = r_count + 1'b1;
                n_res.overflow    = 1'b0;
                n_strobe          = 1'b1;
                n_state           = S_IDLE;
            end
            S_SCAN: begin
                if (finish) begin
                    n_res.result_kind = dist_st.hit ? KIND_NEAR : KIND_NEW;
                    n_res.table_count = r_count;
                    n_res.overflow    = 1'b0;
                    n_strobe          = 1'b1;
                    n_state           = S_IDLE;
                end else if (do_issue) begin
                    n_issue = r_issue + 1'b1;
                    n_rd_v  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_v   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_v   <= n_rd_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue <= n_issue;
        r_res   <= n_res;
        r_req   <= n_req;
        r_xpos  <= n_xpos;
        r_prod  <= PROD_W'(mul_a) * PROD_W'(r_cs);
        r_r2    <= R2_W'(r_radius) * R2_W'(r_radius);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs     <= 10'd50;
            r_ox     <= '0;
            r_oy     <= '0;
            r_lvl    <= 7'd50;
            r_radius <= 16'd150;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CELL_SIZE: r_cs     <= i_cfg_data[9:0];
                CFG_ORIGIN_X:  r_ox     <= i_cfg_data;
                CFG_ORIGIN_Y:  r_oy     <= i_cfg_data;
                CFG_OCC_LEVEL: r_lvl    <= i_cfg_data[6:0];
                CFG_RADIUS:    r_radius <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

`ifndef SYNTH
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> !busy)
        else $error("result strobe while sequencer busy");

    a_point_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type == REQ_POINT) |=> (busy && !o_res_strobe))
        else $error("scan point finished without walking the table");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> (o_res.table_count <= CNT_W'(TABLE_DEPTH)))
        else $error("table count beyond depth");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.overflow)
            |-> (o_res.result_kind == KIND_ACK && o_res.table_count == CNT_W'(TABLE_DEPTH)))
        else $error("overflow flagged with table not full");
`endif

endmodule
